[design/srpe_pkg.sv]
// Shared types, constants and helpers for the sparse row position encoder.
// Used by srpe_coder and sparse_row_position_encoder; depends on nothing.

package srpe_pkg;

   localparam int COL_W    = 10;
   localparam int DIM_W    = 11;
   localparam int CODE_W   = 13;
   localparam int LEN_W    = 4;
   localparam int PIX_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DIM_CAP        = 1024;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(DIM_CAP);

   localparam logic [CSR_IDX_W-1:0] REG_ROW_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;

   localparam logic [PIX_W-1:0] PIX_EMPTY = 2'd0;
   localparam logic [PIX_W-1:0] PIX_ONE   = 2'd1;
   localparam logic [PIX_W-1:0] PIX_TWO   = 2'd2;
   localparam logic [PIX_W-1:0] PIX_THREE = 2'd3;

   localparam logic [2:0] PREFIX_ONE   = 3'b011;
   localparam logic [2:0] PREFIX_TWO   = 3'b101;
   localparam logic [2:0] PREFIX_THREE = 3'b100;

   typedef struct packed {
      logic [COL_W-1:0] column_index;
      logic [COL_W-1:0] prior_nonzero_column;
      logic             seen_nonzero;
      logic [COL_W-1:0] row_index;
   } state_type;

   typedef struct packed {
      logic              emit;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
      logic              row_end;
      logic              image_end;
   } result_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      r = v;
      if (r == '0) r = DIM_W'(1);
      if (r > lim) r = lim;
      return r;
   endfunction

endpackage

[design/srpe_coder.sv]
// Per-element coding logic: position test, gap width, prefix pack, next state.
// Depends on srpe_pkg.

module srpe_coder #(
   parameter int MAX_WIDTH  = srpe_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = srpe_pkg::DEF_MAX_HEIGHT
) (
   input  logic [srpe_pkg::PIX_W-1:0] pixel_value,
   input  logic [srpe_pkg::DIM_W-1:0] row_width,
   input  logic [srpe_pkg::DIM_W-1:0] image_rows,
   input  srpe_pkg::state_type        st_cur,
   output srpe_pkg::state_type        st_next,
   output srpe_pkg::result_type       result
);

   localparam int WidthLim  = (MAX_WIDTH  < srpe_pkg::DIM_CAP) ? MAX_WIDTH  : srpe_pkg::DIM_CAP;
   localparam int HeightLim = (MAX_HEIGHT < srpe_pkg::DIM_CAP) ? MAX_HEIGHT : srpe_pkg::DIM_CAP;

   logic [srpe_pkg::DIM_W-1:0]  w;
   logic [srpe_pkg::DIM_W-1:0]  h;
   logic                        last_col;
   logic                        last_row;
   logic signed [12:0]          remain;
   logic [srpe_pkg::COL_W-1:0]  rem_m1;
   logic [3:0]                  b;
   logic [2:0]                  prefix;
   logic [srpe_pkg::LEN_W-1:0]  plen;
   logic [srpe_pkg::COL_W-1:0]  gap_raw;
   logic [srpe_pkg::COL_W-1:0]  gap;

   always_comb begin
      w = srpe_pkg::clamp_dim(row_width,  srpe_pkg::DIM_W'(WidthLim));
      h = srpe_pkg::clamp_dim(image_rows, srpe_pkg::DIM_W'(HeightLim));
      last_col = {1'b0, st_cur.column_index} >= (w - srpe_pkg::DIM_W'(1));
      last_row = {1'b0, st_cur.row_index} >= (h - srpe_pkg::DIM_W'(1));

      remain = $signed({2'b00, w}) - $signed({3'b000, st_cur.prior_nonzero_column})
               - $signed({12'd0, st_cur.seen_nonzero});
      rem_m1 = srpe_pkg::COL_W'(remain - 13'sd1);
      b = 4'd1;
      if (remain > 13'sd1) begin
         for (int i = 0; i < srpe_pkg::COL_W; i++) begin
            if (rem_m1[i]) b = 4'(i + 1);
         end
      end

      case (pixel_value)
         srpe_pkg::PIX_ONE: begin
            prefix = srpe_pkg::PREFIX_ONE;
            plen   = 4'd2;
         end
         srpe_pkg::PIX_TWO: begin
            prefix = srpe_pkg::PREFIX_TWO;
            plen   = 4'd3;
         end
         srpe_pkg::PIX_THREE: begin
            prefix = srpe_pkg::PREFIX_THREE;
            plen   = 4'd3;
         end
         default: begin
            prefix = 3'b000;
            plen   = 4'd0;
         end
      endcase

      gap_raw = st_cur.seen_nonzero
                ? st_cur.column_index - st_cur.prior_nonzero_column - srpe_pkg::COL_W'(1)
                : st_cur.column_index;
      gap = gap_raw & ~({srpe_pkg::COL_W{1'b1}} << b);

      result.row_end   = last_col;
      result.image_end = last_col && last_row;
      if (pixel_value == srpe_pkg::PIX_EMPTY) begin
         result.emit        = last_col;
         result.code_bits   = '0;
         result.code_length = srpe_pkg::LEN_W'(1);
      end else begin
         result.emit        = 1'b1;
         result.code_bits   = (srpe_pkg::CODE_W'(prefix) << b) | srpe_pkg::CODE_W'(gap);
         result.code_length = plen + b;
      end

      st_next = st_cur;
      if (pixel_value != srpe_pkg::PIX_EMPTY) begin
         st_next.seen_nonzero         = 1'b1;
         st_next.prior_nonzero_column = st_cur.column_index;
      end
      if (last_col) begin
         st_next.column_index         = '0;
         st_next.prior_nonzero_column = '0;
         st_next.seen_nonzero         = 1'b0;
         st_next.row_index = last_row ? '0 : st_cur.row_index + srpe_pkg::COL_W'(1);
      end else begin
         st_next.column_index = st_cur.column_index + srpe_pkg::COL_W'(1);
      end
   end

endmodule

[design/sparse_row_position_encoder.sv]
// Top level of the sparse row position encoder: input stage, coder, result register.
// Depends on srpe_pkg and srpe_coder.
//
//   channel | direction | transaction
//   req_    | in        | one 2-bit matrix element, raster order
//   rsp_    | out       | one code word with length, row end and image end marks
//   csr_    | in        | write of row_width (index 0) or image_rows (index 1)
//
// One element per cycle sustained unless rsp_ stalls; rsp_ reads the result register.
// The input register and result register each hold one transaction; the row state
// advances when an element moves from the input register into the result register.
// A stalled rsp_ stops that move and back-pressures req_ through the input register.
// Synchronous reset clears the state and restores both dimensions to 1024.

module sparse_row_position_encoder #(
   parameter int MAX_WIDTH  = srpe_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = srpe_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [srpe_pkg::PIX_W-1:0]      req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [srpe_pkg::CODE_W-1:0]     rsp_code_bits,
   output logic [srpe_pkg::LEN_W-1:0]      rsp_code_length,
   output logic                            rsp_row_end,
   output logic                            rsp_image_end,
   input  logic                            csr_write_en,
   input  logic [srpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srpe_pkg::DIM_W-1:0]      csr_wdata
);

   logic                        in_valid_ff;
   logic [srpe_pkg::PIX_W-1:0]  in_pixel_ff;
   logic                        in_advance;
   logic [srpe_pkg::DIM_W-1:0]  row_width_ff;
   logic [srpe_pkg::DIM_W-1:0]  image_rows_ff;
   srpe_pkg::state_type         st_ff;
   srpe_pkg::state_type         st_in;
   srpe_pkg::result_type        res;
   logic                        out_valid_ff;
   logic [srpe_pkg::CODE_W-1:0] out_code_ff;
   logic [srpe_pkg::LEN_W-1:0]  out_len_ff;
   logic                        out_row_end_ff;
   logic                        out_image_end_ff;

   srpe_coder #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_coder (
      .pixel_value (in_pixel_ff),
      .row_width   (row_width_ff),
      .image_rows  (image_rows_ff),
      .st_cur      (st_ff),
      .st_next     (st_in),
      .result      (res)
   );

   always_comb begin
      in_advance = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready  = !in_valid_ff || in_advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         st_ff         <= '0;
         row_width_ff  <= srpe_pkg::DIM_RESET;
         image_rows_ff <= srpe_pkg::DIM_RESET;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               srpe_pkg::REG_ROW_WIDTH:  row_width_ff  <= csr_wdata;
               srpe_pkg::REG_IMAGE_ROWS: image_rows_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_ready) in_valid_ff <= req_valid;
         if (in_advance) begin
            st_ff        <= st_in;
            out_valid_ff <= res.emit;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_pixel_ff <= req_pixel_value;
      if (in_advance && res.emit) begin
         out_code_ff      <= res.code_bits;
         out_len_ff       <= res.code_length;
         out_row_end_ff   <= res.row_end;
         out_image_end_ff <= res.image_end;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_bits   = out_code_ff;
   assign rsp_code_length = out_len_ff;
   assign rsp_row_end     = out_row_end_ff;
   assign rsp_image_end   = out_image_end_ff;

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code_length >= 4'd1 && rsp_code_length <= 4'd13))
      else $error("code length out of range");

   a_image_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_row_end)
      else $error("image end without row end");

   a_empty_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_length == 4'd1 |-> rsp_code_bits == '0 && rsp_row_end)
      else $error("single-bit code outside last column");

   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      in_advance && res.row_end |=> st_ff.column_index == '0 && !st_ff.seen_nonzero)
      else $error("row state not cleared after last column");

   a_prior_clear: assert property (@(posedge clock) disable iff (reset)
      !st_ff.seen_nonzero |-> st_ff.prior_nonzero_column == '0)
      else $error("prior column held without a coded element");

endmodule
